/* src/gcai_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcai_pkg
// Shared constants for the great-circle arc intersection pipeline.
// ----------------------------------------------------------------------------
package gcai_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int FIELD_W       = 32;
    localparam int TOL_W         = 21;
    localparam logic [TOL_W-1:0] TOL_RESET = 21'd1074;

    // plane normals saturate to +/- this value
    localparam longint NORM_LIMIT = 64'sd2147483647;

    // square root unit: 64-bit radicand, 32-bit root
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

endpackage

/* src/gcai_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcai_isqrt
// Pipelined floor square root, one root bit per stage, with sideband data.
// ----------------------------------------------------------------------------
module gcai_isqrt
    import gcai_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_x,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int N  = ROOT_W;
    localparam int RW = ROOT_W + 4;

    logic [N-1:0]      r_vld;
    logic [RW-1:0]     r_rem  [0:N-1];
    logic [ROOT_W-1:0] r_root [0:N-1];
    logic [RAD_W-1:0]  r_x    [0:N-1];
    logic [SIDE_W-1:0] r_side [0:N-1];

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_stage
            localparam int I = N - 1 - j;
            logic              v_in;
            logic [RW-1:0]     rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [RAD_W-1:0]  x_in;
            logic [SIDE_W-1:0] side_in;
            logic [RW-1:0]     sh;
            logic [RW-1:0]     trial;
            logic [RW-1:0]     n_rem;
            logic [ROOT_W-1:0] n_root;

            if (j == 0) begin : g_first
                assign v_in    = i_valid;
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = i_x;
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_vld[j-1];
                assign rem_in  = r_rem[j-1];
                assign root_in = r_root[j-1];
                assign x_in    = r_x[j-1];
                assign side_in = r_side[j-1];
            end

            // bring down the next bit pair, try root*4+1
            always_comb begin
                sh    = {rem_in[RW-3:0], x_in[2*I+1 -: 2]};
                trial = RW'({root_in, 2'b01});
                if (sh >= trial) begin
                    n_rem  = sh - trial;
                    n_root = {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = sh;
                    n_root = {root_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_vld[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j]  <= n_rem;
                    r_root[j] <= n_root;
                    r_x[j]    <= x_in;
                    r_side[j] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

/* src/gcai_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcai_div
// Three-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage. Quotients are known to fit in FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module gcai_div
    import gcai_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [2:0][FRAC_BITS+ROOT_W-1:0] i_num,
    input  logic [ROOT_W-1:0]               i_den,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic [2:0][FRAC_BITS:0]         o_q,
    output logic [SIDE_W-1:0]               o_side
);

    localparam int NW = FRAC_BITS + ROOT_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int N  = FRAC_BITS + 1;

    logic [N-1:0]              r_vld;
    logic [2:0][NW-1:0]        r_num  [0:N-1];
    logic [2:0][ROOT_W-1:0]    r_rem  [0:N-1];
    logic [2:0][QW-1:0]        r_q    [0:N-1];
    logic [ROOT_W-1:0]         r_den  [0:N-1];
    logic [SIDE_W-1:0]         r_side [0:N-1];

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_stage
            localparam int K = FRAC_BITS - j;
            logic                   v_in;
            logic [2:0][NW-1:0]     num_in;
            logic [2:0][ROOT_W-1:0] rem_in;
            logic [2:0][QW-1:0]     q_in;
            logic [ROOT_W-1:0]      den_in;
            logic [SIDE_W-1:0]      side_in;
            logic [2:0][ROOT_W-1:0] n_rem;
            logic [2:0][QW-1:0]     n_q;

            if (j == 0) begin : g_first
                always_comb begin
                    for (int l = 0; l < 3; l++) begin
                        rem_in[l] = ROOT_W'(i_num[l][NW-1:FRAC_BITS+1]);
                    end
                end
                assign v_in    = i_valid;
                assign num_in  = i_num;
                assign q_in    = '0;
                assign den_in  = i_den;
                assign side_in = i_side;
            end else begin : g_next
                assign v_in    = r_vld[j-1];
                assign num_in  = r_num[j-1];
                assign rem_in  = r_rem[j-1];
                assign q_in    = r_q[j-1];
                assign den_in  = r_den[j-1];
                assign side_in = r_side[j-1];
            end

            always_comb begin
                logic [ROOT_W:0] sh;
                logic [ROOT_W:0] diff;
                for (int l = 0; l < 3; l++) begin
                    sh     = {rem_in[l], num_in[l][K]};
                    diff   = sh - {1'b0, den_in};
                    n_q[l] = q_in[l];
                    if (sh >= {1'b0, den_in}) begin
                        n_rem[l]  = diff[ROOT_W-1:0];
                        n_q[l][K] = 1'b1;
                    end else begin
                        n_rem[l]  = sh[ROOT_W-1:0];
                        n_q[l][K] = 1'b0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_vld[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[j]  <= num_in;
                    r_rem[j]  <= n_rem;
                    r_q[j]    <= n_q;
                    r_den[j]  <= den_in;
                    r_side[j] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[N-1];
    assign o_q     = r_q[N-1];
    assign o_side  = r_side[N-1];

endmodule

/* src/great_circle_arc_intersect_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_arc_intersect_unit
// Intersection point of two great-circle arcs, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | in        | i_valid / o_ready     | i_arc{1,2}_{start,end}_{x,y,z}
//  out     | out       | o_valid / i_ready     | o_found, o_point_{x,y,z}
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_tolerance
//
//  One pair accepted per cycle while o_ready is high; the depth is set by the
//  32-stage square root and the FRAC_BITS+1 stage divider.
//  Reset clears all valid bits and loads the default tolerance.
//  A result held at the output while i_ready is low freezes the whole pipeline;
//  nothing is dropped or duplicated. Config writes are always taken.
// ----------------------------------------------------------------------------
module great_circle_arc_intersect_unit
    import gcai_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [FIELD_W-1:0] i_arc1_start_x,
    input  logic signed [FIELD_W-1:0] i_arc1_start_y,
    input  logic signed [FIELD_W-1:0] i_arc1_start_z,
    input  logic signed [FIELD_W-1:0] i_arc1_end_x,
    input  logic signed [FIELD_W-1:0] i_arc1_end_y,
    input  logic signed [FIELD_W-1:0] i_arc1_end_z,
    input  logic signed [FIELD_W-1:0] i_arc2_start_x,
    input  logic signed [FIELD_W-1:0] i_arc2_start_y,
    input  logic signed [FIELD_W-1:0] i_arc2_start_z,
    input  logic signed [FIELD_W-1:0] i_arc2_end_x,
    input  logic signed [FIELD_W-1:0] i_arc2_end_y,
    input  logic signed [FIELD_W-1:0] i_arc2_end_z,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_found,
    output logic signed [FIELD_W-1:0] o_point_x,
    output logic signed [FIELD_W-1:0] o_point_y,
    output logic signed [FIELD_W-1:0] o_point_z,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [TOL_W-1:0]          i_cfg_tolerance
);

    localparam int F   = FRAC_BITS;
    localparam int CW  = F + 2;
    localparam int PW  = 2 * CW;
    localparam int PW1 = PW + 1;
    localparam int DW  = (2 * F + 4 > TOL_W + F + 2) ? 2 * F + 4 : TOL_W + F + 2;
    localparam int NW  = F + ROOT_W;
    localparam int QW  = F + 1;
    localparam int MW  = 31;
    localparam int YW  = 64;

    localparam logic signed [FIELD_W-1:0] POS_ONE = FIELD_W'(64'sd1 <<< F);
    localparam logic signed [FIELD_W-1:0] NEG_ONE = -POS_ONE;
    localparam logic signed [DW-1:0]      ONE_SQ  = DW'(1) << (2 * F);
    localparam logic signed [PW1-1:0]     NL_POS  = PW1'(NORM_LIMIT);
    localparam logic signed [PW1-1:0]     NL_NEG  = -NL_POS;

    localparam int SQ_SIDE_W = 12 * CW + 2 * DW + 5 + 3 * MW;
    localparam int DV_SIDE_W = 12 * CW + 2 * DW + 5;

    function automatic logic [CW-1:0] sat_in(input logic signed [FIELD_W-1:0] v);
        logic [CW-1:0] r;
        if (v > POS_ONE) begin
            r = POS_ONE[CW-1:0];
        end else if (v < NEG_ONE) begin
            r = NEG_ONE[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    logic en;
    logic [TOL_W-1:0] r_tol;
    logic signed [DW-1:0] t_w;
    logic signed [DW-1:0] thr;

    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;
    assign t_w         = $signed(DW'(r_tol)) <<< F;
    assign thr         = ONE_SQ - t_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_tolerance;
        end
    end

    logic signed [FIELD_W-1:0] in_raw [0:11];
    assign in_raw[0]  = i_arc1_start_x;
    assign in_raw[1]  = i_arc1_start_y;
    assign in_raw[2]  = i_arc1_start_z;
    assign in_raw[3]  = i_arc1_end_x;
    assign in_raw[4]  = i_arc1_end_y;
    assign in_raw[5]  = i_arc1_end_z;
    assign in_raw[6]  = i_arc2_start_x;
    assign in_raw[7]  = i_arc2_start_y;
    assign in_raw[8]  = i_arc2_start_z;
    assign in_raw[9]  = i_arc2_end_x;
    assign in_raw[10] = i_arc2_end_y;
    assign in_raw[11] = i_arc2_end_z;

    // ---------------- front valid line (stages 1..11)
    logic [10:0] r_vf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
        end else if (en) begin
            r_vf <= {r_vf[9:0], i_valid};
        end
    end

    // ---------------- registers, stages 1..11
    logic [11:0][CW-1:0] r_pt1, r_pt2, r_pt3, r_pt4, r_pt5, r_pt6;
    logic [11:0][CW-1:0] r_pt7, r_pt8, r_pt9, r_pt10, r_pt11;
    logic [11:0][CW-1:0] n_pt1;
    logic signed [PW-1:0] r_pd2 [0:5], n_pd2 [0:5];
    logic signed [PW-1:0] r_pc2 [0:11], n_pc2 [0:11];
    logic signed [DW-1:0] r_ab3, r_ab4, r_ab5, r_ab6, r_ab7, r_ab8, r_ab9, r_ab10, r_ab11;
    logic signed [DW-1:0] r_cd3, r_cd4, r_cd5, r_cd6, r_cd7, r_cd8, r_cd9, r_cd10, r_cd11;
    logic signed [DW-1:0] n_ab3, n_cd3;
    logic signed [31:0]   r_n3 [0:5], n_n3 [0:5];
    logic                 r_short4, r_short5, r_short6, r_short7, r_short8;
    logic                 r_short9, r_short10, r_short11;
    logic signed [YW-1:0] r_py4 [0:5], n_py4 [0:5];
    logic signed [YW-1:0] r_y5 [0:2], n_y5 [0:2];
    logic [2:0]           r_neg6, r_neg7, r_neg8, r_neg9, r_neg10, r_neg11, n_neg6;
    logic [YW-2:0]        r_mag6 [0:2], r_mag7 [0:2], r_mag8 [0:2], n_mag6 [0:2];
    logic [YW-2:0]        r_or6, n_or6;
    logic [7:0]           r_gnz7, n_gnz7;
    logic [2:0]           r_gpos7 [0:7], n_gpos7 [0:7];
    logic                 r_zero7, r_zero8, r_zero9, r_zero10, r_zero11;
    logic [5:0]           r_p8, n_p8;
    logic [MW-1:0]        r_m9 [0:2], r_m10 [0:2], r_m11 [0:2], n_m9 [0:2];
    logic [2*MW-1:0]      r_sq10 [0:2], n_sq10 [0:2];
    logic [RAD_W-1:0]     r_sum11, n_sum11;

    always_comb begin
        for (int i = 0; i < 12; i++) begin
            n_pt1[i] = sat_in(in_raw[i]);
        end
    end

    // stage 2: all products of the endpoint dots and the plane normals
    always_comb begin
        int j1;
        int j2;
        for (int k = 0; k < 3; k++) begin
            j1 = (k + 1) % 3;
            j2 = (k + 2) % 3;
            n_pd2[k]       = $signed(r_pt1[k]) * $signed(r_pt1[3+k]);
            n_pd2[3+k]     = $signed(r_pt1[6+k]) * $signed(r_pt1[9+k]);
            n_pc2[2*k]     = $signed(r_pt1[j1]) * $signed(r_pt1[3+j2]);
            n_pc2[2*k+1]   = $signed(r_pt1[j2]) * $signed(r_pt1[3+j1]);
            n_pc2[6+2*k]   = $signed(r_pt1[6+j1]) * $signed(r_pt1[9+j2]);
            n_pc2[6+2*k+1] = $signed(r_pt1[6+j2]) * $signed(r_pt1[9+j1]);
        end
    end

    // stage 3: dot sums, normals floor-shifted and saturated
    always_comb begin
        logic signed [PW1-1:0] diff;
        logic signed [PW1-1:0] sh;
        n_ab3 = DW'(r_pd2[0]) + DW'(r_pd2[1]) + DW'(r_pd2[2]);
        n_cd3 = DW'(r_pd2[3]) + DW'(r_pd2[4]) + DW'(r_pd2[5]);
        for (int k = 0; k < 6; k++) begin
            diff = PW1'(r_pc2[2*k]) - PW1'(r_pc2[2*k+1]);
            sh   = diff >>> F;
            if (sh > NL_POS) begin
                sh = NL_POS;
            end else if (sh < NL_NEG) begin
                sh = NL_NEG;
            end
            n_n3[k] = sh[31:0];
        end
    end

    // stage 4: products of the cross of the two normals
    always_comb begin
        int j1;
        int j2;
        for (int k = 0; k < 3; k++) begin
            j1 = (k + 1) % 3;
            j2 = (k + 2) % 3;
            n_py4[2*k]   = r_n3[j1] * r_n3[3+j2];
            n_py4[2*k+1] = r_n3[j2] * r_n3[3+j1];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_y5[k] = r_py4[2*k] - r_py4[2*k+1];
        end
    end

    // stage 6: sign and magnitude; OR of magnitudes has the top bit of the max
    always_comb begin
        logic signed [YW-1:0] ng;
        n_or6 = '0;
        for (int k = 0; k < 3; k++) begin
            ng        = -r_y5[k];
            n_neg6[k] = r_y5[k][YW-1];
            n_mag6[k] = n_neg6[k] ? ng[YW-2:0] : r_y5[k][YW-2:0];
            n_or6     = n_or6 | n_mag6[k];
        end
    end

    // stage 7: leading one per byte
    always_comb begin
        logic [YW-1:0] w;
        logic [7:0]    by;
        w = {1'b0, r_or6};
        for (int g = 0; g < 8; g++) begin
            by         = w[8*g +: 8];
            n_gnz7[g]  = |by;
            n_gpos7[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (by[b]) n_gpos7[g] = 3'(b);
            end
        end
    end

    // stage 8: highest nonzero byte gives the leading one position
    always_comb begin
        n_p8 = '0;
        for (int g = 0; g < 8; g++) begin
            if (r_gnz7[g]) n_p8 = {3'(g), r_gpos7[g]};
        end
    end

    // stage 9: align so the largest magnitude sits in [2^30, 2^31)
    always_comb begin
        logic [YW+31:0] wide;
        logic [6:0]     amt;
        amt = {1'b0, r_p8} + 7'd2;
        for (int k = 0; k < 3; k++) begin
            wide    = {1'b0, r_mag8[k], 32'd0} >> amt;
            n_m9[k] = wide[MW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sq10[k] = r_m9[k] * r_m9[k];
        end
        n_sum11 = RAD_W'(r_sq10[0]) + RAD_W'(r_sq10[1]) + RAD_W'(r_sq10[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt1 <= n_pt1;
            r_pt2 <= r_pt1;
            r_pd2 <= n_pd2;
            r_pc2 <= n_pc2;
            r_pt3 <= r_pt2;
            r_ab3 <= n_ab3;
            r_cd3 <= n_cd3;
            r_n3  <= n_n3;
            r_pt4 <= r_pt3;
            r_ab4 <= r_ab3;
            r_cd4 <= r_cd3;
            r_short4 <= (r_ab3 >= thr) || (r_cd3 >= thr);
            r_py4 <= n_py4;
            r_pt5 <= r_pt4;
            r_ab5 <= r_ab4;
            r_cd5 <= r_cd4;
            r_short5 <= r_short4;
            r_y5  <= n_y5;
            r_pt6 <= r_pt5;
            r_ab6 <= r_ab5;
            r_cd6 <= r_cd5;
            r_short6 <= r_short5;
            r_neg6 <= n_neg6;
            r_mag6 <= n_mag6;
            r_or6  <= n_or6;
            r_pt7 <= r_pt6;
            r_ab7 <= r_ab6;
            r_cd7 <= r_cd6;
            r_short7 <= r_short6;
            r_neg7 <= r_neg6;
            r_mag7 <= r_mag6;
            r_gnz7 <= n_gnz7;
            r_gpos7 <= n_gpos7;
            r_zero7 <= ~|r_or6;
            r_pt8 <= r_pt7;
            r_ab8 <= r_ab7;
            r_cd8 <= r_cd7;
            r_short8 <= r_short7;
            r_neg8 <= r_neg7;
            r_mag8 <= r_mag7;
            r_zero8 <= r_zero7;
            r_p8 <= n_p8;
            r_pt9 <= r_pt8;
            r_ab9 <= r_ab8;
            r_cd9 <= r_cd8;
            r_short9 <= r_short8;
            r_neg9 <= r_neg8;
            r_zero9 <= r_zero8;
            r_m9 <= n_m9;
            r_pt10 <= r_pt9;
            r_ab10 <= r_ab9;
            r_cd10 <= r_cd9;
            r_short10 <= r_short9;
            r_neg10 <= r_neg9;
            r_zero10 <= r_zero9;
            r_m10 <= r_m9;
            r_sq10 <= n_sq10;
            r_pt11 <= r_pt10;
            r_ab11 <= r_ab10;
            r_cd11 <= r_cd10;
            r_short11 <= r_short10;
            r_neg11 <= r_neg10;
            r_zero11 <= r_zero10;
            r_m11 <= r_m10;
            r_sum11 <= n_sum11;
        end
    end

    // ---------------- square root
    logic [SQ_SIDE_W-1:0] sq_side_i, sq_side_o;
    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    logic [11:0][CW-1:0]  sq_pt;
    logic signed [DW-1:0] sq_ab, sq_cd;
    logic                 sq_short, sq_zero;
    logic [2:0]           sq_neg;
    logic [MW-1:0]        sq_m0, sq_m1, sq_m2;

    assign sq_side_i = {r_pt11, r_ab11, r_cd11, r_short11, r_zero11, r_neg11,
                        r_m11[0], r_m11[1], r_m11[2]};
    assign {sq_pt, sq_ab, sq_cd, sq_short, sq_zero, sq_neg, sq_m0, sq_m1, sq_m2} = sq_side_o;

    gcai_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vf[10]),
        .i_x     (r_sum11),
        .i_side  (sq_side_i),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side_o)
    );

    // ---------------- stage 12: rounded numerators
    logic                 r_v12;
    logic [2:0][NW-1:0]   r_num12, n_num12;
    logic [ROOT_W-1:0]    r_s12;
    logic [11:0][CW-1:0]  r_pt12;
    logic signed [DW-1:0] r_ab12, r_cd12;
    logic                 r_short12, r_zero12;
    logic [2:0]           r_neg12;

    always_comb begin
        n_num12[0] = NW'({sq_m0, {F{1'b0}}}) + NW'(sq_root[ROOT_W-1:1]);
        n_num12[1] = NW'({sq_m1, {F{1'b0}}}) + NW'(sq_root[ROOT_W-1:1]);
        n_num12[2] = NW'({sq_m2, {F{1'b0}}}) + NW'(sq_root[ROOT_W-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v12 <= 1'b0;
        end else if (en) begin
            r_v12 <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num12   <= n_num12;
            r_s12     <= sq_root;
            r_pt12    <= sq_pt;
            r_ab12    <= sq_ab;
            r_cd12    <= sq_cd;
            r_short12 <= sq_short;
            r_zero12  <= sq_zero;
            r_neg12   <= sq_neg;
        end
    end

    // ---------------- divider
    logic [DV_SIDE_W-1:0] dv_side_i, dv_side_o;
    logic                 dv_valid;
    logic [2:0][QW-1:0]   dv_q;
    logic [11:0][CW-1:0]  dv_pt;
    logic signed [DW-1:0] dv_ab, dv_cd;
    logic                 dv_short, dv_zero;
    logic [2:0]           dv_neg;

    assign dv_side_i = {r_pt12, r_ab12, r_cd12, r_short12, r_zero12, r_neg12};
    assign {dv_pt, dv_ab, dv_cd, dv_short, dv_zero, dv_neg} = dv_side_o;

    gcai_div #(
        .FRAC_BITS (F),
        .SIDE_W    (DV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v12),
        .i_num   (r_num12),
        .i_den   (r_s12),
        .i_side  (dv_side_i),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_side  (dv_side_o)
    );

    // ---------------- back end: sign, containment dots, flip, compare
    logic [4:0]           r_vb;
    logic signed [CW-1:0] r_x1 [0:2], n_x1 [0:2];
    logic [11:0][CW-1:0]  r_pt_b1;
    logic signed [PW-1:0] r_xp2 [0:11], n_xp2 [0:11];
    logic signed [CW-1:0] r_x2 [0:2], r_x3 [0:2], r_x4 [0:2], n_x4 [0:2];
    logic signed [DW-1:0] r_dx3 [0:3], n_dx3 [0:3];
    logic signed [DW-1:0] r_dx4 [0:3], n_dx4 [0:3];
    logic signed [DW-1:0] r_ab_b [1:4], r_cd_b [1:4];
    logic                 r_short_b [1:4], r_zero_b [1:4];
    logic                 r_found, n_found;
    logic signed [FIELD_W-1:0] r_px, r_py, r_pz;

    always_comb begin
        logic signed [CW-1:0] qv;
        for (int k = 0; k < 3; k++) begin
            qv      = $signed(CW'(dv_q[k]));
            n_x1[k] = dv_neg[k] ? -qv : qv;
        end
    end

    always_comb begin
        for (int i = 0; i < 12; i++) begin
            n_xp2[i] = $signed(r_pt_b1[i]) * r_x1[i % 3];
        end
    end

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            n_dx3[g] = DW'(r_xp2[3*g]) + DW'(r_xp2[3*g+1]) + DW'(r_xp2[3*g+2]);
        end
    end

    // turn X toward the first arc start
    always_comb begin
        for (int g = 0; g < 4; g++) begin
            n_dx4[g] = r_dx3[0][DW-1] ? -r_dx3[g] : r_dx3[g];
        end
        for (int k = 0; k < 3; k++) begin
            n_x4[k] = r_dx3[0][DW-1] ? -r_x3[k] : r_x3[k];
        end
    end

    always_comb begin
        n_found = !r_short_b[4] && !r_zero_b[4]
               && (r_ab_b[4] < r_dx4[0] + t_w) && (r_ab_b[4] < r_dx4[1] + t_w)
               && (r_cd_b[4] < r_dx4[2] + t_w) && (r_cd_b[4] < r_dx4[3] + t_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else if (en) begin
            r_vb <= {r_vb[3:0], dv_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1         <= n_x1;
            r_pt_b1      <= dv_pt;
            r_ab_b[1]    <= dv_ab;
            r_cd_b[1]    <= dv_cd;
            r_short_b[1] <= dv_short;
            r_zero_b[1]  <= dv_zero;
            r_xp2        <= n_xp2;
            r_x2         <= r_x1;
            r_dx3        <= n_dx3;
            r_x3         <= r_x2;
            r_dx4        <= n_dx4;
            r_x4         <= n_x4;
            for (int s = 2; s <= 4; s++) begin
                r_ab_b[s]    <= r_ab_b[s-1];
                r_cd_b[s]    <= r_cd_b[s-1];
                r_short_b[s] <= r_short_b[s-1];
                r_zero_b[s]  <= r_zero_b[s-1];
            end
            r_found <= n_found;
            r_px    <= n_found ? FIELD_W'(r_x4[0]) : '0;
            r_py    <= n_found ? FIELD_W'(r_x4[1]) : '0;
            r_pz    <= n_found ? FIELD_W'(r_x4[2]) : '0;
        end
    end

    assign o_valid   = r_vb[4];
    assign o_found   = r_found;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_point_z = r_pz;

endmodule

/* src/gcai_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcai_checker
// Port-level checks for the arc intersection unit, bound to the top level.
// ----------------------------------------------------------------------------
module gcai_checker
    import gcai_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic signed [FIELD_W-1:0] i_arc1_start_x,
    input logic signed [FIELD_W-1:0] i_arc1_start_y,
    input logic signed [FIELD_W-1:0] i_arc1_start_z,
    input logic signed [FIELD_W-1:0] i_arc1_end_x,
    input logic signed [FIELD_W-1:0] i_arc1_end_y,
    input logic signed [FIELD_W-1:0] i_arc1_end_z,
    input logic signed [FIELD_W-1:0] i_arc2_start_x,
    input logic signed [FIELD_W-1:0] i_arc2_start_y,
    input logic signed [FIELD_W-1:0] i_arc2_start_z,
    input logic signed [FIELD_W-1:0] i_arc2_end_x,
    input logic signed [FIELD_W-1:0] i_arc2_end_y,
    input logic signed [FIELD_W-1:0] i_arc2_end_z,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic                      o_found,
    input logic signed [FIELD_W-1:0] o_point_x,
    input logic signed [FIELD_W-1:0] o_point_y,
    input logic signed [FIELD_W-1:0] o_point_z
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_point_z))
        else $error("output transfer changed while stalled");

    // a waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid
            && $stable(i_arc1_start_x) && $stable(i_arc1_start_y)
            && $stable(i_arc1_start_z) && $stable(i_arc1_end_x)
            && $stable(i_arc1_end_y) && $stable(i_arc1_end_z)
            && $stable(i_arc2_start_x) && $stable(i_arc2_start_y)
            && $stable(i_arc2_start_z) && $stable(i_arc2_end_x)
            && $stable(i_arc2_end_y) && $stable(i_arc2_end_z))
        else $error("input transfer changed while waiting");

    // a stalled output must back-pressure the input
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input ready while output stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_point_x == 0 && o_point_y == 0 && o_point_z == 0)
        else $error("point not zero on a miss");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind great_circle_arc_intersect_unit gcai_checker u_gcai_checker (.*);
